@@ hw/rtl/triangle_rasterizer_zbuffer_unit_defines.svh @@
// Assertion macros for the rasterizer RTL
`ifndef TRIANGLE_RASTERIZER_ZBUFFER_UNIT_DEFINES_SVH
`define TRIANGLE_RASTERIZER_ZBUFFER_UNIT_DEFINES_SVH

// cond holds at every clock edge out of reset
`define TRZB_ASSERT(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the cycle after ante
`define TRZB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/trzb_pkg.sv @@
// Shared types and constants of the triangle rasterizer
package trzb_pkg;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_VERTEX = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	// |area| stays below 2^33
	localparam int DIV_W  = 34;
	localparam int ZQ_W   = 16;
	localparam int ZNUM_W = DIV_W + ZQ_W;
	localparam int SQ_W   = 6;
	localparam int SNUM_W = 48;
	localparam int WORD_W = 21;

	// blank, shade, depth
	localparam logic [WORD_W-1:0] CLEAR_WORD = {1'b1, 4'd0, 16'h8000};

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] depth;
		logic [8:0]         intensity;
		logic [6:0]         read_x;
		logic [5:0]         read_y;
	} item_t;

	typedef struct packed {
		logic [3:0] pixel_shade;
		logic       pixel_blank;
	} pix_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [8:0]         inten;
	} vtx_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_TRI,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		vtx_t       v0;
		vtx_t       v1;
		vtx_t       v2;
		logic [6:0] rx;
		logic [5:0] ry;
	} job_t;

	typedef struct packed {
		logic init_busy;
	} back_stat_t;

endpackage

@@ hw/rtl/trzb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
module trzb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hw/rtl/trzb_div.sv @@
// Restoring divider, one quotient bit per cycle
module trzb_div #(
	parameter int NW = 50,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic          busy,
	output logic [QW-1:0] quo
);
	localparam int CW = $clog2(QW + 1);

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] den_q;
	logic [QW-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den << (QW - 1);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (rem_q >= den_q) begin
				rem_q <= rem_q - den_q;
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			den_q <= den_q >> 1;
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
endmodule

@@ hw/rtl/trzb_fifo.sv @@
// Two-entry job queue between front and back
`include "triangle_rasterizer_zbuffer_unit_defines.svh"

module trzb_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  trzb_pkg::job_t  din,
	output logic            full,
	input  logic            pop,
	output trzb_pkg::job_t  dout,
	output logic            nonempty
);
	trzb_pkg::job_t ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign dout     = ent_q[rp_q];

	`TRZB_ASSERT(a_no_overflow, clk, arst_n, !(push && cnt_q == 2'd2), "push into full queue")
	`TRZB_ASSERT(a_no_underflow, clk, arst_n, !(pop && cnt_q == 2'd0), "pop from empty queue")
	`TRZB_ASSERT_NXT(a_count_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "count lost a beat")
endmodule

@@ hw/rtl/trzb_front.sv @@
// Front end: accepts command beats, latches vertices, queues jobs
module trzb_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  trzb_pkg::item_t        cmd,
	input  trzb_pkg::back_stat_t   stat,
	input  logic                   full,
	output logic                   push,
	output trzb_pkg::job_t         job
);
	trzb_pkg::vtx_t vtx_q [2];
	trzb_pkg::vtx_t vnew;
	logic [1:0]     cnt_q;
	logic           accept;
	logic           is_vtx;

	assign cmd_stall = full | stat.init_busy;
	assign accept    = cmd_valid & ~cmd_stall;
	assign is_vtx    = (cmd.func == trzb_pkg::FUNC_VERTEX);
	assign vnew      = {cmd.pos_x, cmd.pos_y, cmd.depth, cmd.intensity};

	always_comb begin
		job.op = trzb_pkg::OP_TRI;
		job.v0 = vtx_q[0];
		job.v1 = vtx_q[1];
		job.v2 = vnew;
		job.rx = cmd.read_x;
		job.ry = cmd.read_y;
		unique case (cmd.func)
			trzb_pkg::FUNC_CLEAR: begin
				push   = accept;
				job.op = trzb_pkg::OP_CLEAR;
			end
			trzb_pkg::FUNC_VERTEX: begin
				push = accept && (cnt_q == 2'd2);
			end
			trzb_pkg::FUNC_READ: begin
				push   = accept;
				job.op = trzb_pkg::OP_READ;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && is_vtx) begin
			cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_vtx && cnt_q != 2'd2) begin
			vtx_q[cnt_q[0]] <= vnew;
		end
	end
endmodule

@@ hw/rtl/trzb_back.sv @@
// Back end: clear sweep, triangle walk with depth test, pixel reads
module trzb_back #(
	parameter int SCREEN_W = 128,
	parameter int SCREEN_H = 64,
	parameter int LEVELS   = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	input  trzb_pkg::job_t         job,
	output logic                   job_pop,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output trzb_pkg::pix_t         rsp,
	output trzb_pkg::back_stat_t   stat
);
	localparam int XW    = $clog2(SCREEN_W);
	localparam int YW    = $clog2(SCREEN_H);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int DW    = trzb_pkg::DIV_W;
	localparam int ZW    = trzb_pkg::ZNUM_W;
	localparam int SW    = trzb_pkg::SNUM_W;
	localparam int WW    = trzb_pkg::WORD_W;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_PROD,
		ST_BOX,
		ST_EDGE,
		ST_WGT,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_RESP
	} state_t;

	function automatic logic signed [12:0] lo_clamp(input logic signed [15:0] a,
			input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m = (a < b) ? a : b;
		m = (m < c) ? m : c;
		m = m >>> 4;
		return (m < 0) ? 13'sd0 : 13'(m);
	endfunction

	function automatic logic signed [12:0] hi_clamp(input logic signed [15:0] a,
			input logic signed [15:0] b, input logic signed [15:0] c,
			input logic signed [12:0] lim);
		logic signed [15:0] m;
		m = (a > b) ? a : b;
		m = (m > c) ? m : c;
		m = m >>> 4;
		return (13'(m) > lim) ? lim : 13'(m);
	endfunction

	state_t         state_q;
	logic           init_q;
	logic [AW-1:0]  clr_addr_q;
	logic [XW-1:0]  x_q;
	logic [YW-1:0]  y_q;
	logic           rsp_valid_q;
	trzb_pkg::pix_t rsp_q;

	trzb_pkg::vtx_t     v0_q, v1_q, v2_q;
	logic               oob_q;
	logic signed [16:0] e0x_q, e0y_q, e1x_q, e1y_q;
	logic signed [33:0] p1_q, p2_q;
	logic               sgn_q;
	logic [DW-1:0]      d_q;
	logic [XW-1:0]      bx0_q, bx1_q;
	logic [YW-1:0]      by1_q;
	logic signed [34:0] m1_q, m2_q, m3_q, m4_q;
	logic [DW-1:0]      ww_q, wu_q, wv_q;
	logic signed [50:0] zp0_q, zp1_q, zp2_q;
	logic [42:0]        ip0_q, ip1_q, ip2_q;

	logic signed [12:0] bx_lo, bx_hi, by_lo, by_hi;
	logic               box_empty;
	logic signed [34:0] dr;
	logic [DW-1:0]      d_abs;
	logic signed [17:0] pxd, pyd;
	logic signed [35:0] nu_r, nv_r;
	logic signed [36:0] nu, nv;
	logic signed [37:0] nw;
	logic               covered;
	logic signed [52:0] zsum, zn;
	logic [44:0]        isum;
	logic [ZW-1:0]      znum;
	logic [SW-1:0]      snum;
	logic               div_start;
	logic               zbusy, sbusy, div_done;
	logic [trzb_pkg::ZQ_W-1:0] zq;
	logic [trzb_pkg::SQ_W-1:0] sq;
	logic signed [15:0] z_new, z_old;
	logic [3:0]         shade;
	logic [XW+6:0]      rx_ext;
	logic [YW+5:0]      ry_ext;
	logic               rd_oob;
	logic [XW-1:0]      nxt_x;
	logic [YW-1:0]      nxt_y;
	state_t             nxt_st;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [WW-1:0]      ram_wdata, ram_rdata;

	// triangle setup
	assign bx_lo     = lo_clamp(v0_q.x, v1_q.x, v2_q.x);
	assign bx_hi     = hi_clamp(v0_q.x, v1_q.x, v2_q.x, 13'(SCREEN_W - 1));
	assign by_lo     = lo_clamp(v0_q.y, v1_q.y, v2_q.y);
	assign by_hi     = hi_clamp(v0_q.y, v1_q.y, v2_q.y, 13'(SCREEN_H - 1));
	assign box_empty = (bx_lo > bx_hi) || (by_lo > by_hi);
	assign dr        = 35'(p1_q) - 35'(p2_q);
	assign d_abs     = DW'(dr[34] ? -dr : dr);

	// edge functions at the current pixel
	assign pxd  = 18'($signed({1'b0, x_q, 4'b0000})) - 18'(v0_q.x);
	assign pyd  = 18'($signed({1'b0, y_q, 4'b0000})) - 18'(v0_q.y);
	assign nu_r = 36'(m1_q) - 36'(m2_q);
	assign nv_r = 36'(m3_q) - 36'(m4_q);
	assign nu   = sgn_q ? -37'(nu_r) : 37'(nu_r);
	assign nv   = sgn_q ? -37'(nv_r) : 37'(nv_r);
	assign nw   = 38'($signed({1'b0, d_q})) - 38'(nu) - 38'(nv);
	assign covered = !nu[36] && !nv[36] && !nw[37];

	// weighted sums, depth biased to stay non-negative
	assign zsum = 53'(zp0_q) + 53'(zp1_q) + 53'(zp2_q);
	assign zn   = zsum + 53'($signed({1'b0, d_q, 15'b0}));
	assign znum = ZW'(zn);
	assign isum = 45'(ip0_q) + 45'(ip1_q) + 45'(ip2_q);
	assign snum = SW'(isum) * SW'(LEVELS);

	assign div_start = (state_q == ST_SUM);
	assign div_done  = !zbusy && !sbusy;

	trzb_div #(.NW(ZW), .QW(trzb_pkg::ZQ_W)) u_zdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (znum),
		.den    (ZW'(d_q)),
		.busy   (zbusy),
		.quo    (zq)
	);

	trzb_div #(.NW(SW), .QW(trzb_pkg::SQ_W)) u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (snum),
		.den    (SW'({d_q, 8'b0})),
		.busy   (sbusy),
		.quo    (sq)
	);

	assign z_new = $signed({~zq[15], zq[14:0]});
	assign z_old = $signed(ram_rdata[15:0]);
	assign shade = (sq >= trzb_pkg::SQ_W'(LEVELS - 1)) ? 4'(LEVELS - 1) : sq[3:0];

	// read address
	assign rx_ext  = (XW + 7)'(job.rx);
	assign ry_ext  = (YW + 6)'(job.ry);
	assign rd_oob  = (32'(job.rx) >= SCREEN_W) || (32'(job.ry) >= SCREEN_H);
	assign job_pop = (state_q == ST_IDLE) && job_valid;

	// bounding box walk
	always_comb begin
		if (x_q == bx1_q) begin
			nxt_x  = bx0_q;
			nxt_y  = y_q + 1'b1;
			nxt_st = (y_q == by1_q) ? ST_IDLE : ST_EDGE;
		end else begin
			nxt_x  = x_q + 1'b1;
			nxt_y  = y_q;
			nxt_st = ST_EDGE;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = trzb_pkg::CLEAR_WORD;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_DIV && div_done && z_new > z_old) begin
			ram_we    = 1'b1;
			ram_waddr = {y_q, x_q};
			ram_wdata = {1'b0, shade, z_new};
		end
	end

	assign ram_re    = (job_pop && job.op == trzb_pkg::OP_READ && !rd_oob)
			|| (state_q == ST_WGT && covered);
	assign ram_raddr = (state_q == ST_IDLE) ? {ry_ext[YW-1:0], rx_ext[XW-1:0]} : {y_q, x_q};

	trzb_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			init_q      <= 1'b1;
			clr_addr_q  <= '0;
			x_q         <= '0;
			y_q         <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (state_q == ST_RESP && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (job_valid) begin
						unique case (job.op)
							trzb_pkg::OP_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							trzb_pkg::OP_TRI:  state_q <= ST_SETUP;
							trzb_pkg::OP_READ: state_q <= ST_RESP;
							default:           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SETUP: state_q <= ST_PROD;
				ST_PROD:  state_q <= ST_BOX;
				ST_BOX: begin
					if (dr == '0 || box_empty) begin
						state_q <= ST_IDLE;
					end else begin
						x_q     <= bx_lo[XW-1:0];
						y_q     <= by_lo[YW-1:0];
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: state_q <= ST_WGT;
				ST_WGT: begin
					if (covered) begin
						state_q <= ST_MUL;
					end else begin
						x_q     <= nxt_x;
						y_q     <= nxt_y;
						state_q <= nxt_st;
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						x_q     <= nxt_x;
						y_q     <= nxt_y;
						state_q <= nxt_st;
					end
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						if (oob_q) begin
							rsp_q <= '{pixel_shade: 4'd0, pixel_blank: 1'b1};
						end else begin
							rsp_q <= '{pixel_shade: ram_rdata[19:16], pixel_blank: ram_rdata[20]};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			v0_q  <= job.v0;
			v1_q  <= job.v1;
			v2_q  <= job.v2;
			oob_q <= rd_oob;
		end
		if (state_q == ST_SETUP) begin
			e0x_q <= 17'(v1_q.x) - 17'(v0_q.x);
			e0y_q <= 17'(v1_q.y) - 17'(v0_q.y);
			e1x_q <= 17'(v2_q.x) - 17'(v0_q.x);
			e1y_q <= 17'(v2_q.y) - 17'(v0_q.y);
		end
		if (state_q == ST_PROD) begin
			p1_q <= e0x_q * e1y_q;
			p2_q <= e1x_q * e0y_q;
		end
		if (state_q == ST_BOX) begin
			sgn_q <= dr[34];
			d_q   <= d_abs;
			bx0_q <= bx_lo[XW-1:0];
			bx1_q <= bx_hi[XW-1:0];
			by1_q <= by_hi[YW-1:0];
		end
		if (state_q == ST_EDGE) begin
			m1_q <= pxd * e1y_q;
			m2_q <= e1x_q * pyd;
			m3_q <= e0x_q * pyd;
			m4_q <= pxd * e0y_q;
		end
		if (state_q == ST_WGT) begin
			ww_q <= DW'(nw);
			wu_q <= DW'(nu);
			wv_q <= DW'(nv);
		end
		if (state_q == ST_MUL) begin
			zp0_q <= $signed({1'b0, ww_q}) * v0_q.z;
			zp1_q <= $signed({1'b0, wu_q}) * v1_q.z;
			zp2_q <= $signed({1'b0, wv_q}) * v2_q.z;
			ip0_q <= ww_q * v0_q.inten;
			ip1_q <= wu_q * v1_q.inten;
			ip2_q <= wv_q * v2_q.inten;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;
	assign stat.init_busy = init_q;
endmodule

@@ hw/rtl/triangle_rasterizer_zbuffer_unit.sv @@
// Triangle rasterizer with depth buffer: top level
//
// Command channel (cmd_valid / cmd_stall / cmd) takes one beat per command:
// clear buffers, load vertex, or read pixel. Every third vertex closes a
// triangle. Response channel (rsp_valid / rsp_stall / rsp) returns one beat
// per read: shade index and blank flag.
// Commands pass through a two-entry queue to the back end, which handles
// one job at a time in order.
// Per job: a clear writes every buffer address, one RAM row per cycle. A
// read issues its RAM read as the job is popped and registers its response
// beat in ST_RESP. A triangle runs ST_SETUP, ST_PROD and ST_BOX, then walks
// its clamped bounding box: each pixel passes ST_EDGE and ST_WGT, and one
// inside also ST_MUL, ST_SUM and ST_DIV, where the 16-step divider runs.
// After reset the back end sweeps the whole buffer (same length as a clear)
// and cmd_stall stays high until it finishes.
// A stalled response holds its beat; the back end then waits on the next
// read while the queue keeps taking commands until it is full.
module triangle_rasterizer_zbuffer_unit #(
	parameter int SCREEN_W = 128,
	parameter int SCREEN_H = 64,
	parameter int LEVELS   = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  trzb_pkg::item_t cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output trzb_pkg::pix_t  rsp
);
	trzb_pkg::back_stat_t stat;
	trzb_pkg::job_t       job_in, job_out;
	logic                 full, push, pop, nonempty;

	trzb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.stat      (stat),
		.full      (full),
		.push      (push),
		.job       (job_in)
	);

	trzb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (job_in),
		.full     (full),
		.pop      (pop),
		.dout     (job_out),
		.nonempty (nonempty)
	);

	trzb_back #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H),
		.LEVELS   (LEVELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (nonempty),
		.job       (job_out),
		.job_pop   (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.stat      (stat)
	);
endmodule
